// ===== sv/hrp_pkg.sv =====
// Package for the HTTP request head parser: state and result types, phase,
// event and error codes, literal tables and small helper functions.
// Depends on nothing; every other file imports it.
package hrp_pkg;

    // Parse phases.
    localparam logic [2:0] PH_METHOD = 3'd0;
    localparam logic [2:0] PH_TARGET = 3'd1;
    localparam logic [2:0] PH_PROTO  = 3'd2;
    localparam logic [2:0] PH_KEY    = 3'd3;
    localparam logic [2:0] PH_VALUE  = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_FAULT  = 3'd6;
    localparam logic [2:0] PH_UNUSED = 3'd7;

    // Event kinds.
    localparam logic [2:0] EV_METHOD   = 3'd0;
    localparam logic [2:0] EV_TARGET   = 3'd1;
    localparam logic [2:0] EV_KEY      = 3'd2;
    localparam logic [2:0] EV_VALUE    = 3'd3;
    localparam logic [2:0] EV_HDR_END  = 3'd4;
    localparam logic [2:0] EV_HEAD_END = 3'd5;
    localparam logic [2:0] EV_ERROR    = 3'd6;

    // Error codes.
    localparam logic [2:0] ERR_TRUNCATED = 3'd0;
    localparam logic [2:0] ERR_METHOD    = 3'd1;
    localparam logic [2:0] ERR_TOKEN     = 3'd2;
    localparam logic [2:0] ERR_PROTOCOL  = 3'd3;
    localparam logic [2:0] ERR_HEADER    = 3'd4;

    // Method codes; NONE marks that no live candidate is complete.
    localparam logic [1:0] METH_GET  = 2'd0;
    localparam logic [1:0] METH_POST = 2'd1;
    localparam logic [1:0] METH_PUT  = 2'd2;
    localparam logic [1:0] METH_NONE = 2'd3;

    // Characters.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [3:0] PROTO_LEN = 4'd8;
    localparam logic [3:0] IDX_MAX   = 4'd15;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] lit_idx;
        logic [2:0] cand;
        logic       held_colon;
        logic       held_cr;
        logic       line_empty;
        logic       proto_ok;
    } t_state;

    localparam t_state ST_RESET = '{
        phase: PH_METHOD, lit_idx: 4'd0, cand: 3'b111, held_colon: 1'b0,
        held_cr: 1'b0, line_empty: 1'b1, proto_ok: 1'b0
    };

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [1:0] meth;
        logic [2:0] err;
        logic       last;
    } t_res;

    // Up to two results from one item, in order.
    typedef struct packed {
        logic [1:0] cnt;
        t_res       e0;
        t_res       e1;
    } t_push;

    function automatic t_res mk_res(input logic [2:0] kind, input logic [7:0] data,
                                    input logic [1:0] meth, input logic [2:0] err);
        t_res r;
        r.kind = kind;
        r.data = data;
        r.meth = meth;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic t_push push(input t_push p, input t_res e);
        t_push q;
        q = p;
        if (p.cnt == 2'd0) begin
            q.e0  = e;
            q.cnt = 2'd1;
        end else if (p.cnt == 2'd1) begin
            q.e1  = e;
            q.cnt = 2'd2;
        end
        return q;
    endfunction

    function automatic logic [3:0] verb_len(input logic [1:0] k);
        logic [3:0] n;
        unique case (k)
            METH_GET:  n = 4'd3;
            METH_POST: n = 4'd4;
            METH_PUT:  n = 4'd3;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] verb_char(input logic [1:0] k, input logic [1:0] i);
        logic [7:0] c;
        unique case ({k, i})
            {METH_GET, 2'd0}:  c = 8'h47; // G
            {METH_GET, 2'd1}:  c = 8'h45; // E
            {METH_GET, 2'd2}:  c = 8'h54; // T
            {METH_POST, 2'd0}: c = 8'h50; // P
            {METH_POST, 2'd1}: c = 8'h4F; // O
            {METH_POST, 2'd2}: c = 8'h53; // S
            {METH_POST, 2'd3}: c = 8'h54; // T
            {METH_PUT, 2'd0}:  c = 8'h50; // P
            {METH_PUT, 2'd1}:  c = 8'h55; // U
            {METH_PUT, 2'd2}:  c = 8'h54; // T
            default:           c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] proto_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0: c = 8'h48; // H
            3'd1: c = 8'h54; // T
            3'd2: c = 8'h54; // T
            3'd3: c = 8'h50; // P
            3'd4: c = 8'h2F; // /
            3'd5: c = 8'h31; // 1
            3'd6: c = 8'h2E; // .
            3'd7: c = 8'h31; // 1
        endcase
        return c;
    endfunction

    // First live method whose full length has been matched, else METH_NONE.
    function automatic logic [1:0] full_method(input logic [2:0] cand,
                                               input logic [3:0] idx);
        logic [1:0] m;
        priority if (cand[0] && verb_len(METH_GET) == idx) begin
            m = METH_GET;
        end else if (cand[1] && verb_len(METH_POST) == idx) begin
            m = METH_POST;
        end else if (cand[2] && verb_len(METH_PUT) == idx) begin
            m = METH_PUT;
        end else begin
            m = METH_NONE;
        end
        return m;
    endfunction

endpackage

// ===== sv/hrp_step.sv =====
// Per-byte parse step: from the current state and one input byte it works
// out the next state and up to two results. Pure combinational logic.
// Depends on hrp_pkg.
module hrp_step (
    input  hrp_pkg::t_state i_state,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_buffer,
    output hrp_pkg::t_state o_next,
    output hrp_pkg::t_push  o_push
);
    import hrp_pkg::*;

    always_comb begin
        t_state     s;
        t_push      p;
        logic       do_plain;
        logic [2:0] mask;
        logic [1:0] fm;
        logic [7:0] b;

        s        = i_state;
        p        = '0;
        do_plain = 1'b0;
        mask     = 3'b000;
        fm       = full_method(i_state.cand, i_state.lit_idx);
        b        = i_data_byte;

        if (i_state.phase < PH_DONE) begin
            if (i_state.held_cr) begin
                s.held_cr = 1'b0;
                if (b == CH_LF) begin
                    unique case (i_state.phase)
                        PH_METHOD: begin
                            p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0,
                                     (fm != METH_NONE) ? ERR_TOKEN : ERR_METHOD));
                            s.phase = PH_FAULT;
                        end
                        PH_TARGET: begin
                            p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_TOKEN));
                            s.phase = PH_FAULT;
                        end
                        PH_PROTO: begin
                            if (i_state.proto_ok || i_state.lit_idx == PROTO_LEN) begin
                                s.phase      = PH_KEY;
                                s.line_empty = 1'b1;
                            end else begin
                                p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_PROTOCOL));
                                s.phase = PH_FAULT;
                            end
                        end
                        PH_KEY: begin
                            if (i_state.line_empty) begin
                                p = push(p, mk_res(EV_HEAD_END, 8'h00, 2'd0, 3'd0));
                                s.phase = PH_DONE;
                            end else begin
                                p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_HEADER));
                                s.phase = PH_FAULT;
                            end
                        end
                        default: begin
                            p = push(p, mk_res(EV_HDR_END, 8'h00, 2'd0, 3'd0));
                            s.phase      = PH_KEY;
                            s.line_empty = 1'b1;
                        end
                    endcase
                end else begin
                    // The held CR was not a line end: release it, then treat the byte.
                    unique case (i_state.phase)
                        PH_METHOD: begin
                            p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_METHOD));
                            s.phase = PH_FAULT;
                        end
                        PH_TARGET: begin
                            p = push(p, mk_res(EV_TARGET, CH_CR, 2'd0, 3'd0));
                            do_plain = 1'b1;
                        end
                        PH_PROTO: begin
                            if (!i_state.proto_ok) begin
                                p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_PROTOCOL));
                                s.phase = PH_FAULT;
                            end else begin
                                do_plain = 1'b1;
                            end
                        end
                        PH_KEY: begin
                            p = push(p, mk_res(EV_KEY, CH_CR, 2'd0, 3'd0));
                            s.line_empty = 1'b0;
                            do_plain     = 1'b1;
                        end
                        default: begin
                            p = push(p, mk_res(EV_VALUE, CH_CR, 2'd0, 3'd0));
                            do_plain = 1'b1;
                        end
                    endcase
                end
            end else if (i_state.held_colon) begin
                s.held_colon = 1'b0;
                if (b == CH_SP) begin
                    s.phase      = PH_VALUE;
                    s.line_empty = 1'b0;
                end else begin
                    p = push(p, mk_res(EV_KEY, CH_COLON, 2'd0, 3'd0));
                    s.line_empty = 1'b0;
                    do_plain     = 1'b1;
                end
            end else begin
                do_plain = 1'b1;
            end
        end

        // Ordinary handling of the byte; the phase is still the current one here.
        if (do_plain) begin
            unique case (i_state.phase)
                PH_METHOD: begin
                    if (b == CH_SP) begin
                        if (fm != METH_NONE) begin
                            p = push(p, mk_res(EV_METHOD, 8'h00, fm, 3'd0));
                            s.phase = PH_TARGET;
                        end else begin
                            p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_METHOD));
                            s.phase = PH_FAULT;
                        end
                    end else if (b == CH_CR) begin
                        s.held_cr = 1'b1;
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            if (i_state.cand[k] && i_state.lit_idx < verb_len(2'(k))
                                && verb_char(2'(k), i_state.lit_idx[1:0]) == b) begin
                                mask[k] = 1'b1;
                            end
                        end
                        s.cand = mask;
                        if (i_state.lit_idx < IDX_MAX) begin
                            s.lit_idx = i_state.lit_idx + 4'd1;
                        end
                        if (mask == 3'b000) begin
                            p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_METHOD));
                            s.phase = PH_FAULT;
                        end
                    end
                end
                PH_TARGET: begin
                    if (b == CH_SP) begin
                        s.phase    = PH_PROTO;
                        s.lit_idx  = 4'd0;
                        s.proto_ok = 1'b0;
                    end else if (b == CH_CR) begin
                        s.held_cr = 1'b1;
                    end else begin
                        p = push(p, mk_res(EV_TARGET, b, 2'd0, 3'd0));
                    end
                end
                PH_PROTO: begin
                    if (b == CH_CR) begin
                        s.held_cr = 1'b1;
                    end else if (i_state.proto_ok) begin
                        // Rest of the request line is skipped.
                    end else if (b == CH_SP) begin
                        if (i_state.lit_idx == PROTO_LEN) begin
                            s.proto_ok = 1'b1;
                        end else begin
                            p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_PROTOCOL));
                            s.phase = PH_FAULT;
                        end
                    end else if (i_state.lit_idx < PROTO_LEN
                                 && proto_char(i_state.lit_idx[2:0]) == b) begin
                        s.lit_idx = i_state.lit_idx + 4'd1;
                    end else begin
                        p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_PROTOCOL));
                        s.phase = PH_FAULT;
                    end
                end
                PH_KEY: begin
                    if (b == CH_COLON) begin
                        s.held_colon = 1'b1;
                    end else if (b == CH_CR) begin
                        s.held_cr = 1'b1;
                    end else begin
                        p = push(p, mk_res(EV_KEY, b, 2'd0, 3'd0));
                        s.line_empty = 1'b0;
                    end
                end
                PH_VALUE: begin
                    if (b == CH_CR) begin
                        s.held_cr = 1'b1;
                    end else begin
                        p = push(p, mk_res(EV_VALUE, b, 2'd0, 3'd0));
                    end
                end
                default: begin
                end
            endcase
        end

        // End of buffer: a head still open is reported as truncated.
        if (i_end_of_buffer) begin
            if (i_state.phase < PH_DONE && s.phase < PH_DONE) begin
                p = '0;
                p = push(p, mk_res(EV_ERROR, 8'h00, 2'd0, ERR_TRUNCATED));
            end
            s = ST_RESET;
        end

        if (p.cnt == 2'd1) begin
            p.e0.last = 1'b1;
        end else if (p.cnt == 2'd2) begin
            p.e1.last = 1'b1;
        end

        o_next = s;
        o_push = p;
    end

endmodule

// ===== sv/hrp_result_queue.sv =====
// Four-entry result queue: takes up to two results per cycle from the parse
// step and hands them out one per cycle on the output while i_stall is low.
// Depends on hrp_pkg.
module hrp_result_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hrp_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_stall,
    output hrp_pkg::t_res  o_head
);
    import hrp_pkg::*;

    t_res                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    // Two free entries are needed whatever the current item produces.
    assign o_room  = (r_count <= QCNT_W'(QDEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_push.cnt);
        n_rd_ptr = pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.e0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push.e1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (32'(r_count) + 32'(i_push.cnt) - 32'(pop)
                                  <= QDEPTH))
        else $error("results pushed into a full queue");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.cnt == 2'd0) |=> (r_count == $past(r_count) - QCNT_W'(1)))
        else $error("queue count did not fall after a lone pop");

endmodule

// ===== sv/http_request_head_parser_core.sv =====
// Top level of the HTTP request head parser: input register, parse state,
// per-byte step logic and the result queue.
// Depends on hrp_pkg, hrp_step and hrp_result_queue.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_data_byte, i_end_of_buffer
//   output   out        o_valid / i_stall  o_event_kind, o_out_byte, o_method_code,
//                                          o_error_code, o_last_of_run
//
// One byte is accepted per cycle while o_stall is low; a byte that yields two
// results sends them out in turn, and the four-entry result queue sets how far
// input and output may drift apart. An accepted byte waits in the input register,
// then its results are written into the result queue. Reset is synchronous and
// needs no clearing pass. A stall on the output backs up into the queue, then into o_stall.
module http_request_head_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_method_code,
    output logic [2:0] o_error_code,
    output logic       o_last_of_run
);
    import hrp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eob;
    t_state     r_state, n_state;
    t_push      step_push;
    t_push      q_push;
    t_res       q_head;
    logic       q_room;
    logic       step_go;
    logic       in_accept;

    assign step_go   = r_in_valid && q_room;
    assign o_stall   = r_in_valid && !q_room;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_eob  <= i_end_of_buffer;
        end
    end

    hrp_step u_step (
        .i_state         (r_state),
        .i_data_byte     (r_in_byte),
        .i_end_of_buffer (r_in_eob),
        .o_next          (n_state),
        .o_push          (step_push)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RESET;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        q_push = step_push;
        if (!step_go) begin
            q_push.cnt = 2'd0;
        end
    end

    hrp_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_room  (q_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (q_head)
    );

    assign o_event_kind  = q_head.kind;
    assign o_out_byte    = q_head.data;
    assign o_method_code = q_head.meth;
    assign o_error_code  = q_head.err;
    assign o_last_of_run = q_head.last;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with no item held");

    a_eob_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && r_in_eob) |=> (r_state == ST_RESET))
        else $error("state not back at reset after end of buffer");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != PH_UNUSED)
        else $error("parse phase reached the unused code");

    a_push_has_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push.cnt == 2'd1) |-> (q_push.e0.last))
        else $error("single result of an item not marked last");

endmodule

// ===== dv/tb_http_request_head_parser_core.sv =====
// Self-checking testbench for http_request_head_parser_core: directed and random request
// buffers go in byte by byte, and every event that comes out is checked against a predictor.
// Depends on hrp_pkg and the parser RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_http_request_head_parser_core;
    import hrp_pkg::*;

    localparam int ITEM_TARGET = 1850;
    localparam int QUIET_TAIL  = 250;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 64;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [7:0] i_data_byte     = '0;
    logic       i_end_of_buffer = 1'b0;
    logic       i_stall         = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_event_kind;
    logic [7:0] o_out_byte;
    logic [1:0] o_method_code;
    logic [2:0] o_error_code;
    logic       o_last_of_run;

    // Mirrors the parser state, turns each accepted byte into the events it should
    // cause, and checks the events that the block delivers in order.
    class event_ledger;
        logic [2:0]  phase;
        logic [3:0]  lit_idx;
        logic [2:0]  cand;
        bit          held_colon;
        bit          held_cr;
        bit          line_empty;
        bit          proto_ok;
        string       verbs[3];
        string       proto;
        t_res        step_events[$];
        t_res        due_events[$];
        int unsigned n_errors;
        int unsigned n_checked;
        int unsigned kind_seen[8];

        function new();
            verbs = '{"GET", "POST", "PUT"};
            proto = "HTTP/1.1";
            n_errors = 0;
            n_checked = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase      = PH_METHOD;
            lit_idx    = '0;
            cand       = 3'b111;
            held_colon = 1'b0;
            held_cr    = 1'b0;
            line_empty = 1'b1;
            proto_ok   = 1'b0;
        endfunction

        function void add_event(logic [2:0] kind, logic [7:0] data = '0,
                                logic [1:0] meth = '0, logic [2:0] err = '0);
            t_res r;
            if (step_events.size() < 2) begin
                r.kind = kind;
                r.data = data;
                r.meth = meth;
                r.err  = err;
                r.last = 1'b0;
                step_events.push_back(r);
            end
        endfunction

        function void raise_fault(logic [2:0] code);
            add_event(EV_ERROR, '0, '0, code);
            phase = PH_FAULT;
        endfunction

        // The live method whose whole text has been matched so far, if any.
        function logic [1:0] complete_verb();
            int k;
            for (k = 0; k < 3; k++)
                if (cand[k] && verbs[k].len() == lit_idx) return 2'(k);
            return METH_NONE;
        endfunction

        function void plain_byte(logic [7:0] b);
            logic [2:0] mask;
            logic [1:0] m;
            int         k;
            case (phase)
                PH_METHOD: begin
                    if (b == CH_SP) begin
                        m = complete_verb();
                        if (m != METH_NONE) begin
                            add_event(EV_METHOD, '0, m);
                            phase = PH_TARGET;
                        end else begin
                            raise_fault(ERR_METHOD);
                        end
                    end else if (b == CH_CR) begin
                        held_cr = 1'b1;
                    end else begin
                        mask = '0;
                        for (k = 0; k < 3; k++)
                            if (cand[k] && lit_idx < verbs[k].len() && verbs[k][lit_idx] == b)
                                mask[k] = 1'b1;
                        cand = mask;
                        if (lit_idx != IDX_MAX) lit_idx++;
                        if (mask == '0) raise_fault(ERR_METHOD);
                    end
                end
                PH_TARGET: begin
                    if (b == CH_SP) begin
                        phase    = PH_PROTO;
                        lit_idx  = '0;
                        proto_ok = 1'b0;
                    end else if (b == CH_CR) begin
                        held_cr = 1'b1;
                    end else begin
                        add_event(EV_TARGET, b);
                    end
                end
                PH_PROTO: begin
                    if (b == CH_CR) begin
                        held_cr = 1'b1;
                    end else if (proto_ok) begin
                        // The rest of the request line is skipped.
                    end else if (b == CH_SP) begin
                        if (lit_idx == PROTO_LEN) proto_ok = 1'b1;
                        else raise_fault(ERR_PROTOCOL);
                    end else if (lit_idx < PROTO_LEN && proto[lit_idx] == b) begin
                        lit_idx++;
                    end else begin
                        raise_fault(ERR_PROTOCOL);
                    end
                end
                PH_KEY: begin
                    if (b == CH_COLON) begin
                        held_colon = 1'b1;
                    end else if (b == CH_CR) begin
                        held_cr = 1'b1;
                    end else begin
                        add_event(EV_KEY, b);
                        line_empty = 1'b0;
                    end
                end
                PH_VALUE: begin
                    if (b == CH_CR) held_cr = 1'b1;
                    else add_event(EV_VALUE, b);
                end
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            if (phase >= PH_DONE) return;
            if (held_cr) begin
                held_cr = 1'b0;
                if (b == CH_LF) begin
                    case (phase)
                        PH_METHOD:
                            raise_fault(complete_verb() != METH_NONE ? ERR_TOKEN : ERR_METHOD);
                        PH_TARGET: raise_fault(ERR_TOKEN);
                        PH_PROTO: begin
                            if (proto_ok || lit_idx == PROTO_LEN) begin
                                phase      = PH_KEY;
                                line_empty = 1'b1;
                            end else begin
                                raise_fault(ERR_PROTOCOL);
                            end
                        end
                        PH_KEY: begin
                            if (line_empty) begin
                                add_event(EV_HEAD_END);
                                phase = PH_DONE;
                            end else begin
                                raise_fault(ERR_HEADER);
                            end
                        end
                        default: begin
                            add_event(EV_HDR_END);
                            phase      = PH_KEY;
                            line_empty = 1'b1;
                        end
                    endcase
                    return;
                end
                // A CR that turned out not to start a line end is an ordinary byte.
                case (phase)
                    PH_METHOD: begin
                        raise_fault(ERR_METHOD);
                        return;
                    end
                    PH_TARGET: add_event(EV_TARGET, CH_CR);
                    PH_PROTO: begin
                        if (!proto_ok) begin
                            raise_fault(ERR_PROTOCOL);
                            return;
                        end
                    end
                    PH_KEY: begin
                        add_event(EV_KEY, CH_CR);
                        line_empty = 1'b0;
                    end
                    default: add_event(EV_VALUE, CH_CR);
                endcase
                plain_byte(b);
                return;
            end
            if (held_colon) begin
                held_colon = 1'b0;
                if (b == CH_SP) begin
                    phase      = PH_VALUE;
                    line_empty = 1'b0;
                    return;
                end
                add_event(EV_KEY, CH_COLON);
                line_empty = 1'b0;
            end
            plain_byte(b);
        endfunction

        // Returns 1 when the byte was parsed rather than ignored.
        function bit note_item(logic [7:0] b, logic eob);
            logic [2:0] was;
            was = phase;
            step_events.delete();
            take_byte(b);
            if (eob) begin
                if (was < PH_DONE && phase < PH_DONE) begin
                    step_events.delete();
                    add_event(EV_ERROR, '0, '0, ERR_TRUNCATED);
                end
                clear_state();
            end
            if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
            foreach (step_events[i]) due_events.push_back(step_events[i]);
            return was < PH_DONE;
        endfunction

        function void compare_field(string what, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                n_errors++;
            end
        endfunction

        function void check_event(logic [2:0] kind, logic [7:0] data, logic [1:0] meth,
                                  logic [2:0] err, logic last);
            t_res want;
            if (due_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual kind %0d byte %0d",
                         $time, kind, data);
                n_errors++;
                return;
            end
            want = due_events.pop_front();
            n_checked++;
            kind_seen[want.kind]++;
            compare_field("event_kind", want.kind, kind);
            compare_field("out_byte", want.data, data);
            compare_field("method_code", want.meth, meth);
            compare_field("error_code", want.err, err);
            compare_field("last_of_run", want.last, last);
        endfunction

        function void flag_leftover();
            if (due_events.size() != 0) begin
                $display("%0t: %0d events expected but never delivered, expected 0, actual %0d",
                         $time, due_events.size(), due_events.size());
                n_errors++;
            end
        endfunction
    endclass

    event_ledger ledger = new();

    logic [7:0]  req[$];
    bit          quiet         = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned long_holds    = 0;
    int unsigned parsed_bytes  = 0;
    int unsigned taken_bytes   = 0;
    int unsigned idle_run      = 0;
    int unsigned buffers       = 0;

    http_request_head_parser_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_out_byte      (o_out_byte),
        .o_method_code   (o_method_code),
        .o_error_code    (o_error_code),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Both handshakes are sampled here with the values the block saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            parsed_bytes += ledger.note_item(i_data_byte, i_end_of_buffer);
            taken_bytes++;
        end
        if (i_rst_n && o_valid && !i_stall)
            ledger.check_event(o_event_kind, o_out_byte, o_method_code, o_error_code,
                               o_last_of_run);
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_run = 0;
        else idle_run++;
        if (idle_run >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb_http_request_head_parser_core NOT OK");
            $finish;
        end
    end

    // Output side: random stall bursts, plus a long hold-off on request so that the
    // result queue fills and the block has to stall its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
                long_hold_req = 1'b0;
                long_holds++;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    function void put_byte(logic [7:0] b);
        req.push_back(b);
    endfunction

    function void put_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) req.push_back(s[i]);
    endfunction

    // Mostly printable, with lone CRs, lone LFs and arbitrary bytes mixed in.
    function logic [7:0] field_byte();
        case ($urandom_range(0, 15))
            0:       return 8'($urandom_range(0, 255));
            1:       return CH_LF;
            2:       return CH_CR;
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    function void build_request();
        case ($urandom_range(0, 2))
            0:       put_text("GET");
            1:       put_text("POST");
            default: put_text("PUT");
        endcase
        put_byte(CH_SP);
        repeat ($urandom_range(0, 10)) put_byte(field_byte());
        put_byte(CH_SP);
        put_text("HTTP/1.1");
        if ($urandom_range(0, 4) == 0) begin
            put_byte(CH_SP);
            repeat ($urandom_range(0, 5)) put_byte(field_byte());
        end
        put_byte(CH_CR);
        put_byte(CH_LF);
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(0, 8)) put_byte(field_byte());
            put_byte(CH_COLON);
            put_byte(CH_SP);
            repeat ($urandom_range(0, 10)) put_byte(field_byte());
            put_byte(CH_CR);
            put_byte(CH_LF);
        end
        put_byte(CH_CR);
        put_byte(CH_LF);
        // Occasionally some body bytes follow, which the block ignores.
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
    endfunction

    // Sends the queued buffer with end_of_buffer on its last byte.
    task automatic send_buffer();
        int i;
        for (i = 0; i < req.size(); i++) begin
            i_valid         <= 1'b1;
            i_data_byte     <= req[i];
            i_end_of_buffer <= (i == req.size() - 1);
            do @(posedge i_clk); while (o_stall);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        req.delete();
        buffers++;
    endtask

    task automatic send_text(string s);
        put_text(s);
        send_buffer();
    endtask

    initial begin
        int shape;
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed buffers: extreme bytes, held CR and colon, skipped line tail,
        // header ends, and each kind of fault.
        put_text("GET /a");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("\015x\012 HTTP/1.1 ab\015c\015\012K\015y:z: v\015w\015\012\015\012");
        send_buffer();
        send_text("POST / HTTP/1.1\015\012\015\012Z");
        send_text("PUT x");
        send_text("PUXa");
        send_text("GET\015\012");
        send_text("GE\015\012");
        send_text("G\015x");
        send_text(" ");
        send_text("GET /\015\012");
        send_text("PUT / HTTP/1.0 ");
        send_text("GET / HTTP/1.1\015x");
        send_text("GET / HTTP/1.\015\012");
        send_text("GET / HTTP/1.1\015\012abc\015\012");
        send_text("GET  HTTP/1.1 \015\012a: \015\012: b\015\012\015\012");
        send_text("POST / HTTP/1.1\015\012k\012v: \012\015\012\015\012");

        // Random buffers: mostly well-formed heads, the rest damaged or pure noise.
        while (parsed_bytes < ITEM_TARGET) begin
            if (buffers == 18 || buffers == 40) long_hold_req = 1'b1;
            if (parsed_bytes > ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
            shape = $urandom_range(0, 19);
            if (shape < 19) build_request();
            if (shape >= 14 && shape <= 16) begin
                repeat ($urandom_range(1, 3)) begin
                    k = $urandom_range(0, req.size() - 1);
                    case ($urandom_range(0, 3))
                        0:       req[k] = CH_CR;
                        1:       req[k] = CH_SP;
                        2:       req[k] = CH_COLON;
                        default: req[k] = 8'($urandom_range(0, 255));
                    endcase
                end
            end else if (shape >= 17 && shape <= 18) begin
                k = $urandom_range(1, req.size() - 1);
                while (req.size() > k) void'(req.pop_back());
            end else if (shape == 19) begin
                repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
            end
            send_buffer();
        end
        i_valid <= 1'b0;

        while (ledger.due_events.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        ledger.flag_leftover();
        $display("Sent %0d buffers, %0d bytes (%0d parsed), %0d long output hold-offs.",
                 buffers, taken_bytes, parsed_bytes, long_holds);
        $display("Checked %0d events: method %0d, target %0d, key %0d, value %0d, %s %0d, %s %0d, %s %0d.",
                 ledger.n_checked, ledger.kind_seen[EV_METHOD], ledger.kind_seen[EV_TARGET],
                 ledger.kind_seen[EV_KEY], ledger.kind_seen[EV_VALUE],
                 "header end", ledger.kind_seen[EV_HDR_END],
                 "head done", ledger.kind_seen[EV_HEAD_END],
                 "error", ledger.kind_seen[EV_ERROR]);
        if (ledger.n_errors == 0) begin
            $display("tb_http_request_head_parser_core OK");
        end else begin
            $display("tb_http_request_head_parser_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hrp_pkg.sv
sv/hrp_step.sv
sv/hrp_result_queue.sv
sv/http_request_head_parser_core.sv
dv/tb_http_request_head_parser_core.sv
